>>> sv/sacwb_pkg.sv
// ----------------------------------------------------------------------------
// sacwb_pkg: shared definitions of the write-back cache
// Opcodes, result kinds, the replacement LFSR constants and the sequencer
// state type used across the cache modules.
// ----------------------------------------------------------------------------
package sacwb_pkg;

  // Request opcodes carried on the slave tuser.
  localparam logic [1:0] OP_READ   = 2'd0;
  localparam logic [1:0] OP_WRITE  = 2'd1;
  localparam logic [1:0] OP_REFILL = 2'd2;

  // Result kinds carried on the master tuser.
  localparam logic [1:0] KIND_READ   = 2'd0;
  localparam logic [1:0] KIND_WRITE  = 2'd1;
  localparam logic [1:0] KIND_WBACK  = 2'd2;
  localparam logic [1:0] KIND_REFILL = 2'd3;

  // Galois LFSR used for victim selection.
  localparam logic [15:0] LFSR_SEED = 16'hACE1;
  localparam logic [15:0] LFSR_TAPS = 16'hB400;

  // Reset value of the associativity register.
  localparam logic [3:0] WAYS_LOG2_RST = 4'd2;

  // Sequencer states, one-hot.
  typedef enum logic [11:0] {
    ST_IDLE   = 12'b0000_0000_0001,
    ST_TRD    = 12'b0000_0000_0010,
    ST_TCMP   = 12'b0000_0000_0100,
    ST_ACC_RD = 12'b0000_0000_1000,
    ST_ACC_WR = 12'b0000_0001_0000,
    ST_MISS   = 12'b0000_0010_0000,
    ST_WB_TAG = 12'b0000_0100_0000,
    ST_WB_RD  = 12'b0000_1000_0000,
    ST_WB_OUT = 12'b0001_0000_0000,
    ST_REQ    = 12'b0010_0000_0000,
    ST_FILL   = 12'b0100_0000_0000,
    ST_FIN    = 12'b1000_0000_0000
  } state_e;

endpackage

>>> sv/set_assoc_writeback_cache.sv
// A request reads and compares the tag of each way in turn, from way 0 up, with one
// comparator until a way matches; a clean miss then issues the refill request. A dirty
// victim first has its tag read and its words sent out as write-back results; after the
// last refill word the answer follows. One request is served at a time; refill words
// are taken one a cycle.
// Reset clears valid and dirty bits at once; line data and tags are not cleared.
// ----------------------------------------------------------------------------
// set_assoc_writeback_cache: set-associative write-back cache
// Word reads and masked writes, write-allocate, random replacement by LFSR,
// write-back of dirty victims and line refill through the stream ports.
// ----------------------------------------------------------------------------
module set_assoc_writeback_cache #(
  parameter int LINES_LOG2      = 8,
  parameter int LINE_BYTES_LOG2 = 6
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [3:0]   cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // address[31:0], write_data[63:32], write_mask[95:64], fill_data[127:96]
  input  logic [127:0] s_axis_tdata,
  // opcode[1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // mem_address[31:0], data_out[63:32], was_hit[64], zero[71:65]
  output logic [71:0]  m_axis_tdata,
  // kind[1:0]
  output logic [1:0]   m_axis_tuser,
  output logic         m_axis_tlast
);
  import sacwb_pkg::*;

  localparam int NL    = 1 << LINES_LOG2;
  localparam int WL2   = LINE_BYTES_LOG2 - 2;
  localparam int TAGW  = 32 - LINE_BYTES_LOG2;
  localparam int DAW   = LINES_LOG2 + WL2;

  state_e state_q, state_d;
  logic [3:0]            ways_q;
  logic [15:0]           lfsr_q, lfsr_next;
  logic [1:0]            op_q;
  logic [31:0]           addr_q, wdata_q, wmask_q;
  logic [LINES_LOG2-1:0] way_q, line_q, line_idx, victim;
  logic [WL2-1:0]        cnt_q;
  logic                  hit_q;
  logic [NL-1:0]         valid_q, dirty_q;

  logic [TAGW-1:0]       tag_mem [NL];
  logic [TAGW-1:0]       tag_rd_q;
  logic [31:0]           data_mem [1 << DAW];
  logic [31:0]           rd_q;

  logic                  out_valid_q;
  logic [1:0]            out_kind_q;
  logic [31:0]           out_addr_q, out_data_q;
  logic                  out_hit_q, out_last_q;

  logic [TAGW-1:0]       g_tag;
  logic [LINES_LOG2-1:0] g_set, g_base, g_wmask;
  logic [4:0]            g_sl;

  logic                  in_acc;
  logic                  out_load;
  logic [63:0]           wb_addr;

  // Address split for the held request.
  sacwb_geom #(
    .LINES_LOG2      (LINES_LOG2),
    .LINE_BYTES_LOG2 (LINE_BYTES_LOG2)
  ) u_geom (
    .addr_i      (addr_q),
    .ways_log2_i (ways_q),
    .tag_o       (g_tag),
    .set_o       (g_set),
    .base_o      (g_base),
    .way_mask_o  (g_wmask),
    .sl_o        (g_sl)
  );

  assign s_axis_tready = ((state_q == ST_IDLE) && !out_valid_q) || (state_q == ST_FILL);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign line_idx      = g_base | way_q;
  assign lfsr_next     = lfsr_q[0] ? ((lfsr_q >> 1) ^ LFSR_TAPS) : (lfsr_q >> 1);
  assign victim        = g_base | (lfsr_next[LINES_LOG2-1:0] & g_wmask);
  assign wb_addr       = ((({32'b0, 32'(tag_rd_q)} << g_sl) | 64'(g_set)) << WL2)
                         | 64'(cnt_q);
  assign out_load      = !out_valid_q &&
                         ((state_q == ST_WB_OUT) || (state_q == ST_REQ) ||
                          (state_q == ST_ACC_WR));

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ways_q <= WAYS_LOG2_RST;
    end else if (cfg_we_i) begin
      ways_q <= cfg_wdata_i;
    end
  end

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && (s_axis_tuser == OP_READ || s_axis_tuser == OP_WRITE)) state_d = ST_TRD;
      end
      ST_TRD: state_d = ST_TCMP;
      ST_TCMP: begin
        if (valid_q[line_idx] && tag_rd_q == g_tag) state_d = ST_ACC_RD;
        else if (way_q == g_wmask) state_d = ST_MISS;
        else state_d = ST_TRD;
      end
      ST_ACC_RD: state_d = ST_ACC_WR;
      ST_ACC_WR: begin
        if (!out_valid_q) state_d = ST_IDLE;
      end
      ST_MISS: begin
        state_d = (valid_q[victim] && dirty_q[victim]) ? ST_WB_TAG : ST_REQ;
      end
      ST_WB_TAG: state_d = ST_WB_RD;
      ST_WB_RD:  state_d = ST_WB_OUT;
      ST_WB_OUT: begin
        if (!out_valid_q) state_d = (&cnt_q) ? ST_REQ : ST_WB_RD;
      end
      ST_REQ: begin
        if (!out_valid_q) state_d = ST_FILL;
      end
      ST_FILL: begin
        if (in_acc && s_axis_tuser == OP_REFILL && (&cnt_q)) state_d = ST_FIN;
      end
      ST_FIN:  state_d = ST_ACC_RD;
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      lfsr_q  <= LFSR_SEED;
      valid_q <= '0;
      dirty_q <= '0;
      way_q   <= '0;
      cnt_q   <= '0;
      hit_q   <= 1'b0;
      line_q  <= '0;
      op_q    <= OP_READ;
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_IDLE: begin
          way_q <= '0;
          hit_q <= 1'b1;
          op_q  <= s_axis_tuser;
        end
        ST_TCMP: begin
          line_q <= line_idx;
          way_q  <= way_q + 1'b1;
        end
        ST_ACC_WR: begin
          if (!out_valid_q && op_q == OP_WRITE) dirty_q[line_q] <= 1'b1;
        end
        ST_MISS: begin
          lfsr_q <= lfsr_next;
          line_q <= victim;
          cnt_q  <= '0;
        end
        ST_WB_OUT: begin
          if (!out_valid_q) begin
            cnt_q <= cnt_q + 1'b1;
            if (&cnt_q) dirty_q[line_q] <= 1'b0;
          end
        end
        ST_FILL: begin
          if (in_acc && s_axis_tuser == OP_REFILL) cnt_q <= cnt_q + 1'b1;
        end
        ST_FIN: begin
          valid_q[line_q] <= 1'b1;
          dirty_q[line_q] <= 1'b0;
          hit_q           <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // Held request payload.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_acc) begin
      addr_q  <= s_axis_tdata[31:0];
      wdata_q <= s_axis_tdata[63:32];
      wmask_q <= s_axis_tdata[95:64];
    end
  end

  // Tag memory: one read and one write port.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_FIN) tag_mem[line_q] <= g_tag;
    if (state_q == ST_TRD) tag_rd_q <= tag_mem[line_idx];
    else if (state_q == ST_WB_TAG) tag_rd_q <= tag_mem[line_q];
  end

  // Line data memory: one read and one write port.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_FILL && in_acc && s_axis_tuser == OP_REFILL) begin
      data_mem[{line_q, cnt_q}] <= s_axis_tdata[127:96];
    end else if (state_q == ST_ACC_WR && !out_valid_q && op_q == OP_WRITE) begin
      data_mem[{line_q, addr_q[LINE_BYTES_LOG2-1:2]}] <= (rd_q & ~wmask_q) | (wdata_q & wmask_q);
    end
    if (state_q == ST_ACC_RD) rd_q <= data_mem[{line_q, addr_q[LINE_BYTES_LOG2-1:2]}];
    else if (state_q == ST_WB_RD) rd_q <= data_mem[{line_q, cnt_q}];
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      case (state_q)
        ST_WB_OUT: begin
          out_kind_q <= KIND_WBACK;
          out_addr_q <= wb_addr[31:0];
          out_data_q <= rd_q;
          out_hit_q  <= 1'b0;
          out_last_q <= 1'b0;
        end
        ST_REQ: begin
          out_kind_q <= KIND_REFILL;
          out_addr_q <= 32'(addr_q >> LINE_BYTES_LOG2);
          out_data_q <= '0;
          out_hit_q  <= 1'b0;
          out_last_q <= 1'b1;
        end
        default: begin
          out_kind_q <= (op_q == OP_WRITE) ? KIND_WRITE : KIND_READ;
          out_addr_q <= '0;
          out_data_q <= (op_q == OP_WRITE) ? 32'b0 : rd_q;
          out_hit_q  <= hit_q;
          out_last_q <= 1'b1;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, out_hit_q, out_data_q, out_addr_q};
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;

`ifndef SYNTHESIS
  // A write-back word waiting for a free output slot is posted next cycle.
  a_wb_post: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WB_OUT && !out_valid_q) |=> out_valid_q)
    else $error("write-back word not posted");
  // The word counter only runs during write-back and refill.
  a_cnt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0) |-> (state_q == ST_FILL || state_q == ST_WB_RD || state_q == ST_WB_OUT))
    else $error("word counter active outside a line transfer");
  // A refill completion always makes its line valid and clean.
  a_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN) |=> (valid_q[line_q] && !dirty_q[line_q]))
    else $error("refilled line not valid and clean");
`endif

endmodule

>>> sv/sacwb_geom.sv
// ----------------------------------------------------------------------------
// sacwb_geom: address split under the current associativity
// Derives set, tag, set base line and way mask from a byte address.
// ----------------------------------------------------------------------------
module sacwb_geom #(
  parameter int LINES_LOG2      = 8,
  parameter int LINE_BYTES_LOG2 = 6
) (
  input  logic [31:0]                   addr_i,
  input  logic [3:0]                    ways_log2_i,
  output logic [31-LINE_BYTES_LOG2:0]   tag_o,
  output logic [LINES_LOG2-1:0]         set_o,
  output logic [LINES_LOG2-1:0]         base_o,
  output logic [LINES_LOG2-1:0]         way_mask_o,
  output logic [4:0]                    sl_o
);
  import sacwb_pkg::*;

  localparam logic [4:0] LL  = 5'(LINES_LOG2);
  localparam logic [5:0] LBL = 6'(LINE_BYTES_LOG2);

  logic [4:0] wl;
  logic [4:0] sl;
  logic [LINES_LOG2-1:0] set_sel_mask;

  // Clamp the associativity to a fully associative cache.
  always_comb begin
    wl = ({1'b0, ways_log2_i} > LL) ? LL : {1'b0, ways_log2_i};
    sl = LL - wl;
  end

  assign set_sel_mask = LINES_LOG2'(({{(LINES_LOG2){1'b0}}, 1'b1} << sl) - 1'b1);
  assign way_mask_o   = LINES_LOG2'(({{(LINES_LOG2){1'b0}}, 1'b1} << wl) - 1'b1);
  assign set_o        = addr_i[LINE_BYTES_LOG2 +: LINES_LOG2] & set_sel_mask;
  assign base_o       = set_o << wl;
  assign tag_o        = (32-LINE_BYTES_LOG2)'(addr_i >> (LBL + {1'b0, sl}));
  assign sl_o         = sl;

endmodule

>>> dv/set_assoc_writeback_cache_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_writeback_cache_tb: self-checking bench of the write-back cache
// A behavioral copy of the cache (tags, dirty bits, line words, victim LFSR,
// pending miss) runs on every accepted request and queues the answers,
// write-back words and refill requests that the cache must send. Directed
// requests come first, then random traffic under several associativity
// settings, with random stalls on both streams.
// ----------------------------------------------------------------------------
module set_assoc_writeback_cache_tb;
  import sacwb_pkg::*;

  localparam int NLINES   = 256;
  localparam int NWORDS   = 16;
  localparam int SETTLE   = 700;
  localparam int HOLD_LEN = 3000;
  localparam int STALL_MAX = 20000;
  localparam logic [1:0] OP_SPARE = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] maddr;
    logic [31:0] data;
    logic        hit;
    logic        last;
  } cache_res_t;

  typedef struct {
    logic [1:0]  op;
    logic [31:0] addr;
    logic [31:0] wdata;
    logic [31:0] mask;
    bit          autofill;
    bit          typed;
    int          exp_n;
    logic [1:0]  exp_kind;
    logic [31:0] exp_maddr;
  } dir_row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [3:0]   cfg_wdata_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [71:0]  m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         m_axis_tlast;

  set_assoc_writeback_cache u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Shadow cache state.
  logic [31:0] sh_tag [NLINES];
  bit          sh_valid [NLINES];
  bit          sh_dirty [NLINES];
  logic [31:0] sh_word [NLINES*NWORDS];
  logic [15:0] sh_lfsr;
  logic [3:0]  sh_ways;
  bit          miss_open;
  logic [1:0]  miss_op;
  logic [31:0] miss_addr, miss_wdata, miss_mask;
  int unsigned fill_cnt, miss_line;

  cache_res_t  cache_results_q[$];
  int          fails = 0;
  bit          calm = 1'b0;
  bit          hold_req = 1'b0;
  logic [17:0] tag_pool [8];
  logic [7:0]  set_pool [4];

  function automatic void push_res(logic [1:0] kind, logic [31:0] maddr, logic [31:0] data,
                                   logic hit, logic last);
    cache_res_t r;
    r.kind = kind; r.maddr = maddr; r.data = data; r.hit = hit; r.last = last;
    cache_results_q.push_back(r);
  endfunction

  // Serve an access from a resident line.
  function automatic void serve(int unsigned line, logic [1:0] op, logic [31:0] addr,
                                logic [31:0] wd, logic [31:0] mask, logic hit);
    int unsigned wi;
    wi = line * NWORDS + addr[5:2];
    if (op == OP_READ) begin
      push_res(KIND_READ, '0, sh_word[wi], hit, 1'b1);
    end else begin
      sh_word[wi] = (sh_word[wi] & ~mask) | (wd & mask);
      sh_dirty[line] = 1'b1;
      push_res(KIND_WRITE, '0, '0, hit, 1'b1);
    end
  endfunction

  // Advance the shadow cache by one request; returns the number of results.
  function automatic int cache_step(logic [1:0] op, logic [31:0] addr, logic [31:0] wd,
                                    logic [31:0] mask, logic [31:0] fill);
    int unsigned wl, sl, set, tag, base, v, lineno;
    int n;
    n = 0;
    wl = (sh_ways > 8) ? 8 : sh_ways;
    sl = 8 - wl;
    if (op == OP_REFILL) begin
      if (!miss_open) return 0;
      sh_word[miss_line * NWORDS + fill_cnt] = fill;
      fill_cnt++;
      if (fill_cnt < NWORDS) return 0;
      sh_tag[miss_line] = miss_addr >> (6 + sl);
      sh_valid[miss_line] = 1'b1;
      sh_dirty[miss_line] = 1'b0;
      miss_open = 1'b0;
      fill_cnt = 0;
      serve(miss_line, miss_op, miss_addr, miss_wdata, miss_mask, 1'b0);
      return 1;
    end
    if (op == OP_SPARE || miss_open) return 0;
    set = (addr >> 6) & ((1 << sl) - 1);
    tag = addr >> (6 + sl);
    base = set << wl;
    for (int i = 0; i < (1 << wl); i++) begin
      if (sh_valid[(base + i) % NLINES] && sh_tag[(base + i) % NLINES] == tag) begin
        serve((base + i) % NLINES, op, addr, wd, mask, 1'b1);
        return 1;
      end
    end
    // Miss: step the LFSR, pick a way, write back a dirty victim.
    sh_lfsr = sh_lfsr[0] ? ((sh_lfsr >> 1) ^ LFSR_TAPS) : (sh_lfsr >> 1);
    v = (base + (sh_lfsr & ((1 << wl) - 1))) % NLINES;
    if (sh_valid[v] && sh_dirty[v]) begin
      lineno = (sh_tag[v] << sl) | set;
      for (int i = 0; i < NWORDS; i++) begin
        push_res(KIND_WBACK, (lineno << 4) + i, sh_word[v * NWORDS + i], 1'b0, 1'b0);
        n++;
      end
      sh_dirty[v] = 1'b0;
    end
    push_res(KIND_REFILL, addr >> 6, '0, 1'b0, 1'b1);
    n++;
    miss_open = 1'b1;
    miss_op = op; miss_addr = addr; miss_wdata = wd; miss_mask = mask;
    miss_line = v;
    fill_cnt = 0;
    return n;
  endfunction

  // Offer one request; entered and left at a falling edge.
  task automatic offer(input logic [1:0] op, input logic [31:0] addr, input logic [31:0] wd,
                       input logic [31:0] mask, input logic [31:0] fill, output int n);
    if (!calm && $urandom_range(0, 99) < 20) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {fill, mask, wd, addr};
    do @(posedge clk_i); while (!s_axis_tready);
    n = cache_step(op, addr, wd, mask, fill);
    @(negedge clk_i);
  endtask

  // Send refill words until the open miss closes, with an ignored access now and then.
  task automatic complete_miss();
    int n;
    while (miss_open) begin
      if ($urandom_range(0, 99) < 4)
        offer(2'($urandom_range(0, 1)), $urandom, $urandom, $urandom, $urandom, n);
      else
        offer(OP_REFILL, $urandom, $urandom, $urandom, $urandom, n);
    end
  endtask

  function automatic logic [31:0] pick_addr();
    if ($urandom_range(0, 99) < 10) return $urandom;
    return {tag_pool[$urandom_range(0, 7)], set_pool[$urandom_range(0, 3)],
            4'($urandom), 2'($urandom)};
  endfunction

  function automatic logic [31:0] pick_mask();
    case ($urandom_range(0, 3))
      0: return '1;
      1: return '0;
      default: return $urandom;
    endcase
  endfunction

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (cache_results_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_ways(input logic [3:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    sh_ways = value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Receiver: random back-pressure, one long hold-off on request.
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_LEN) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        m_axis_tready <= (calm || $urandom_range(0, 99) >= 20);
      end
    end
  end

  // Result checker.
  always @(posedge clk_i) begin
    cache_res_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (cache_results_q.size() == 0) begin
        $error("unexpected result kind=%0d tdata=%h", m_axis_tuser, m_axis_tdata);
        fails++;
      end else begin
        e = cache_results_q.pop_front();
        if (m_axis_tuser !== e.kind) begin
          $error("kind: expected %0d, got %0d", e.kind, m_axis_tuser);
          fails++;
        end
        if (m_axis_tdata[31:0] !== e.maddr) begin
          $error("mem_address: expected %h, got %h", e.maddr, m_axis_tdata[31:0]);
          fails++;
        end
        if (m_axis_tdata[63:32] !== e.data) begin
          $error("data_out: expected %h, got %h", e.data, m_axis_tdata[63:32]);
          fails++;
        end
        if (m_axis_tdata[64] !== e.hit) begin
          $error("was_hit: expected %0d, got %0d", e.hit, m_axis_tdata[64]);
          fails++;
        end
        if (m_axis_tlast !== e.last) begin
          $error("last: expected %0d, got %0d", e.last, m_axis_tlast);
          fails++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    int stall;
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) stall = 0;
    else stall++;
    if (stall > STALL_MAX) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  dir_row_t    dir_rows[$];
  logic [3:0]  ways_plan [7] = '{4'd0, 4'd8, 4'd15, 4'd3, 4'd1, 4'd5, 4'd2};

  initial begin
    int n;
    int items;
    int r;
    logic [1:0] op;
    dir_row_t d;

    // Shadow reset state.
    foreach (sh_valid[i]) begin
      sh_valid[i] = 1'b0; sh_dirty[i] = 1'b0; sh_tag[i] = '0;
    end
    foreach (sh_word[i]) sh_word[i] = '0;
    sh_lfsr = LFSR_SEED;
    sh_ways = WAYS_LOG2_RST;
    miss_open = 1'b0;
    fill_cnt = 0;
    foreach (tag_pool[i]) tag_pool[i] = 18'($urandom);
    tag_pool[0] = '0; tag_pool[1] = '1;
    foreach (set_pool[i]) set_pool[i] = 8'($urandom);
    set_pool[0] = '0; set_pool[1] = '1;

    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed requests: cold miss, extremes of address and mask, ignored cases.
    // The read of 0x1000 evicts the dirty line of address 0: sixteen write-back
    // words, then the refill request.
    dir_rows = '{
      '{OP_READ,   32'h0000_0000, 32'h0,         32'h0,         1, 1, 1, KIND_REFILL, 32'h0},
      '{OP_READ,   32'h0000_0004, 32'h0,         32'h0,         1, 0, 0, KIND_READ,   32'h0},
      '{OP_WRITE,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1, 1, KIND_REFILL,
        32'h03FF_FFFF},
      '{OP_READ,   32'hFFFF_FFFC, 32'h0,         32'h0,         1, 0, 0, KIND_READ,   32'h0},
      '{OP_WRITE,  32'h0000_0000, 32'hFFFF_FFFF, 32'h0,         1, 0, 0, KIND_READ,   32'h0},
      '{OP_REFILL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1, 0, KIND_READ,   32'h0},
      '{OP_SPARE,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1, 0, KIND_READ,   32'h0},
      '{OP_READ,   32'h0000_1000, 32'h0,         32'h0,         0, 1, 17, KIND_REFILL, 32'h40},
      '{OP_READ,   32'h0000_2000, 32'h0,         32'h0,         0, 1, 0, KIND_READ,   32'h0},
      '{OP_WRITE,  32'h0000_2000, 32'h1234_5678, 32'hFFFF_FFFF, 1, 1, 0, KIND_READ,   32'h0},
      '{OP_WRITE,  32'h0000_0040, 32'hA5A5_A5A5, 32'h0F0F_0F0F, 1, 0, 0, KIND_READ,   32'h0},
      '{OP_READ,   32'h0000_0040, 32'h0,         32'h0,         1, 0, 0, KIND_READ,   32'h0}
    };
    foreach (dir_rows[i]) begin
      d = dir_rows[i];
      offer(d.op, d.addr, d.wdata, d.mask, $urandom, n);
      if (d.typed) begin
        if (n != d.exp_n) begin
          $error("result count: expected %0d, got %0d", d.exp_n, n);
          fails++;
        end else if (n > 0 && (cache_results_q[$].kind !== d.exp_kind ||
                               cache_results_q[$].maddr !== d.exp_maddr)) begin
          $error("refill request: expected %0d/%h, got %0d/%h", d.exp_kind, d.exp_maddr,
                 cache_results_q[$].kind, cache_results_q[$].maddr);
          fails++;
        end
      end
      if (d.autofill) complete_miss();
    end

    // Random traffic, one phase per associativity setting.
    foreach (ways_plan[p]) begin
      settle();
      write_ways(ways_plan[p]);
      calm = (p == 3);
      if (p == 1) hold_req = 1'b1;
      if (ways_plan[p] == 4'd0) begin
        // Direct mapped: dirty a line, then evict it from the same set.
        offer(OP_WRITE, 32'h0000_0000, $urandom, '1, $urandom, n);
        complete_miss();
        offer(OP_READ, 32'h0000_4000, '0, '0, $urandom, n);
        complete_miss();
      end
      items = 0;
      while (items < 55) begin
        r = $urandom_range(0, 99);
        if (r < 6) op = OP_SPARE;
        else if (r < 12) op = OP_REFILL;
        else op = 2'($urandom_range(0, 1));
        offer(op, pick_addr(), $urandom, pick_mask(), $urandom, n);
        items++;
        while (miss_open) begin
          offer(OP_REFILL, $urandom, $urandom, $urandom, $urandom, n);
          items++;
          if ($urandom_range(0, 99) < 4) begin
            offer(2'($urandom_range(0, 1)), pick_addr(), $urandom, $urandom, $urandom, n);
          end
        end
      end
    end
    calm = 1'b0;

    settle();
    if (fails == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
